// ===== design/wvm_pkg.sv =====
// wvm_pkg: types, constants and sizes shared by the wavetable voice mixer
// depends on nothing; used by every module of the mixer
package wvm_pkg;

   localparam int NUM_VOICES   = 8;
   localparam int FRAC_BITS    = 12;
   localparam int SAMPLE_DEPTH = 65536;

   localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
   localparam int VIDX_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int DIV_W   = 18 + FRAC_BITS;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int PROD_W  = 25;
   localparam int SUM_W   = PROD_W + VIDX_W + 1;
   localparam int SH_W    = SUM_W - 8;
   localparam int SCL_W   = SH_W + 9;
   localparam int FIN_W   = SCL_W - 8;
   localparam int QDEPTH  = 2;

   localparam logic [1:0] CSR_SAMPLE_RATE   = 2'd0;
   localparam logic [1:0] CSR_MASTER_VOLUME = 2'd1;
   localparam logic [1:0] CSR_MUTED         = 2'd2;

   localparam logic signed [15:0] CLAMP_HI = 16'sh7fff;
   localparam logic signed [15:0] CLAMP_LO = -16'sh7fff;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_START  = 2'd2,
      KIND_VOLUME = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_READ, ST_MUL, ST_ACC, ST_SCALE, ST_FIN
   } back_state_type;

   typedef struct packed {
      kind_type           kind;
      logic [2:0]         voice;
      logic [15:0]        address;
      logic signed [15:0] sample_data;
      logic [16:0]        track_length;
      logic [15:0]        loop_start;
      logic [16:0]        loop_end;
      logic [17:0]        frequency;
      logic [7:0]         voice_volume;
   } req_type;

   typedef struct packed {
      logic [17:0] sample_rate;
      logic [7:0]  master_volume;
      logic        muted;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      req_type head;
      logic [1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_status_type;

endpackage

// ===== design/wvm_divider.sv =====
// wvm_divider: restoring divider, one quotient bit per cycle, for the phase step
// depends on wvm_pkg
module wvm_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wvm_pkg::DIV_W-1:0]   dividend,
   input  logic [17:0]                 divisor,
   output wvm_pkg::div_status_type     status
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [wvm_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [17:0]                 rem_ff, rem_in;
   logic [17:0]                 div_ff, div_in;
   logic [wvm_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [18:0]                 trial;
   logic [18:0]                 diff;
   logic [63:0]                 quo_wide;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[wvm_pkg::DIV_W-1]};
      diff    = trial - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[18]) begin
            rem_in = diff[17:0];
         end else begin
            rem_in = trial[17:0];
         end
         quo_in = {quo_ff[wvm_pkg::DIV_W-2:0], ~diff[18]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == wvm_pkg::DCNT_W'(wvm_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   // saturate to 32 bits
   assign quo_wide        = 64'(quo_ff);
   assign status.done     = done_ff;
   assign status.quotient = (|quo_wide[63:32]) ? 32'hffff_ffff : quo_wide[31:0];

endmodule

// ===== design/wvm_front.sv =====
// wvm_front: takes requests and holds them in a short queue for the back end
// depends on wvm_pkg
module wvm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  wvm_pkg::req_type            req,
   input  logic                        pop,
   output logic                        busy,
   output wvm_pkg::queue_status_type   status
);

   wvm_pkg::req_type entry_ff [wvm_pkg::QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign busy = (count_ff == 2'(wvm_pkg::QDEPTH));
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req;
      end
   end

   assign status.valid = (count_ff != 2'd0);
   assign status.head  = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;

endmodule

// ===== design/wvm_back.sv =====
// wvm_back: voice state, sample memory and the shared mac that walks the voices
// depends on wvm_pkg and wvm_divider
module wvm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  wvm_pkg::cfg_type            cfg,
   input  wvm_pkg::queue_status_type   qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic signed [15:0]          rsp_mixed_sample,
   output logic [7:0]                  rsp_done_mask
);

   localparam logic [wvm_pkg::VIDX_W-1:0] LAST = wvm_pkg::VIDX_W'(wvm_pkg::NUM_VOICES - 1);

   logic [15:0] mem [wvm_pkg::SAMPLE_DEPTH];
   logic [15:0] rd_data_ff;
   logic [wvm_pkg::ADDR_W-1:0] rd_addr;

   logic [31:0] pos_ff   [wvm_pkg::NUM_VOICES];
   logic [31:0] vend_ff  [wvm_pkg::NUM_VOICES];
   logic [31:0] lstart_ff[wvm_pkg::NUM_VOICES];
   logic [31:0] lend_ff  [wvm_pkg::NUM_VOICES];
   logic [31:0] step_ff  [wvm_pkg::NUM_VOICES];
   logic [15:0] base_ff  [wvm_pkg::NUM_VOICES];
   logic [7:0]  gain_ff  [wvm_pkg::NUM_VOICES];
   logic [wvm_pkg::NUM_VOICES-1:0] active_ff;

   wvm_pkg::back_state_type state_ff, state_in;
   wvm_pkg::req_type        cur_ff, cur_in;
   logic [wvm_pkg::VIDX_W-1:0] cnt_ff, cnt_in;
   logic signed [wvm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic signed [wvm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [wvm_pkg::SCL_W-1:0]  scl_ff, scl_in;
   logic        keep_ff, keep_in;
   logic [7:0]  done_ff, done_in;
   logic        valid_ff, valid_in;
   logic signed [15:0] mix_ff, mix_in;

   logic        div_start;
   wvm_pkg::div_status_type div_stat;
   logic        vstart;
   logic [31:0] vstart_step;
   logic        vmul;
   logic        vstop;
   logic        vloop;
   logic [32:0] np;
   logic signed [wvm_pkg::SH_W-1:0]  sh;
   logic signed [wvm_pkg::FIN_W-1:0] fin;
   logic [7:0]  mgain;
   logic        head_voice_ok;
   wvm_pkg::req_type           vs_req;
   logic [wvm_pkg::VIDX_W-1:0] vs_idx;
   logic [wvm_pkg::VIDX_W-1:0] vol_idx;

   wvm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({qstat.head.frequency, wvm_pkg::FRAC_BITS'(0)}),
      .divisor  (cfg.sample_rate),
      .status   (div_stat)
   );

   assign head_voice_ok = (32'(qstat.head.voice) < wvm_pkg::NUM_VOICES);
   assign rd_addr = wvm_pkg::ADDR_W'(32'(base_ff[cnt_ff]) + (pos_ff[cnt_ff] >> wvm_pkg::FRAC_BITS));
   assign np      = {1'b0, pos_ff[cnt_ff]} + {1'b0, step_ff[cnt_ff]};
   assign mgain   = cfg.muted ? 8'd0 : cfg.master_volume;
   assign sh      = wvm_pkg::SH_W'(sum_ff >>> 8);
   assign fin     = wvm_pkg::FIN_W'(scl_ff >>> 8);

   // the start source is the queue head when no division runs, else the latched request
   assign vs_req  = (state_ff == wvm_pkg::ST_DIV) ? cur_ff : qstat.head;
   assign vs_idx  = wvm_pkg::VIDX_W'(vs_req.voice);
   assign vol_idx = wvm_pkg::VIDX_W'(qstat.head.voice);

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      prod_in     = prod_ff;
      scl_in      = scl_ff;
      keep_in     = keep_ff;
      done_in     = done_ff;
      valid_in    = 1'b0;
      mix_in      = mix_ff;
      pop         = 1'b0;
      div_start   = 1'b0;
      vstart      = 1'b0;
      vstart_step = 32'd0;
      vmul        = 1'b0;
      vstop       = 1'b0;
      vloop       = 1'b0;
      unique case (state_ff)
         wvm_pkg::ST_IDLE: begin
            if (qstat.valid) begin
               pop    = 1'b1;
               cur_in = qstat.head;
               unique case (qstat.head.kind)
                  wvm_pkg::KIND_TICK: begin
                     cnt_in   = '0;
                     sum_in   = '0;
                     done_in  = 8'd0;
                     state_in = wvm_pkg::ST_READ;
                  end
                  wvm_pkg::KIND_START: begin
                     if (head_voice_ok && cfg.sample_rate != 18'd0) begin
                        div_start = 1'b1;
                        state_in  = wvm_pkg::ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         wvm_pkg::ST_DIV: begin
            if (div_stat.done) begin
               vstart      = 1'b1;
               vstart_step = div_stat.quotient;
               state_in    = wvm_pkg::ST_IDLE;
            end
         end
         wvm_pkg::ST_READ: begin
            state_in = wvm_pkg::ST_MUL;
         end
         wvm_pkg::ST_MUL: begin
            prod_in = $signed(rd_data_ff) * $signed({1'b0, gain_ff[cnt_ff]});
            keep_in = 1'b0;
            if (active_ff[cnt_ff]) begin
               vmul    = 1'b1;
               keep_in = 1'b1;
               if (np >= {1'b0, vend_ff[cnt_ff]}) begin
                  if (lend_ff[cnt_ff] == 32'd0) begin
                     vstop   = 1'b1;
                     keep_in = 1'b0;
                     done_in = done_ff | (8'd1 << cnt_ff);
                  end else begin
                     vloop = 1'b1;
                  end
               end
            end
            state_in = wvm_pkg::ST_ACC;
         end
         wvm_pkg::ST_ACC: begin
            if (keep_ff) begin
               sum_in = sum_ff + wvm_pkg::SUM_W'(prod_ff);
            end
            if (cnt_ff == LAST) begin
               state_in = wvm_pkg::ST_SCALE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = wvm_pkg::ST_READ;
            end
         end
         wvm_pkg::ST_SCALE: begin
            scl_in   = sh * $signed({1'b0, mgain});
            state_in = wvm_pkg::ST_FIN;
         end
         wvm_pkg::ST_FIN: begin
            if (fin > wvm_pkg::FIN_W'(wvm_pkg::CLAMP_HI)) begin
               mix_in = wvm_pkg::CLAMP_HI;
            end else if (fin < wvm_pkg::FIN_W'(wvm_pkg::CLAMP_LO)) begin
               mix_in = wvm_pkg::CLAMP_LO;
            end else begin
               mix_in = 16'(fin);
            end
            valid_in = 1'b1;
            state_in = wvm_pkg::ST_IDLE;
         end
         default: begin
            state_in = wvm_pkg::ST_IDLE;
         end
      endcase
      // start with a zero sample rate: step is zero, no division
      if (state_ff == wvm_pkg::ST_IDLE && qstat.valid && qstat.head.kind == wvm_pkg::KIND_START
          && head_voice_ok && cfg.sample_rate == 18'd0) begin
         vstart = 1'b1;
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (state_ff == wvm_pkg::ST_IDLE && qstat.valid && qstat.head.kind == wvm_pkg::KIND_WRITE) begin
         mem[wvm_pkg::ADDR_W'(qstat.head.address)] <= qstat.head.sample_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < wvm_pkg::NUM_VOICES; i++) begin
            gain_ff[i] <= 8'd0;
         end
      end else begin
         if (state_ff == wvm_pkg::ST_IDLE && qstat.valid
             && qstat.head.kind == wvm_pkg::KIND_VOLUME && head_voice_ok) begin
            gain_ff[vol_idx] <= qstat.head.voice_volume;
         end
         if (vstart) begin
            active_ff[vs_idx] <= 1'b1;
         end
         if (vstop) begin
            active_ff[cnt_ff] <= 1'b0;
         end
      end
      if (vstart) begin
         base_ff  [vs_idx] <= vs_req.address;
         pos_ff   [vs_idx] <= 32'd0;
         vend_ff  [vs_idx] <= 32'(vs_req.track_length) << wvm_pkg::FRAC_BITS;
         lstart_ff[vs_idx] <= 32'(vs_req.loop_start) << wvm_pkg::FRAC_BITS;
         lend_ff  [vs_idx] <= 32'(vs_req.loop_end) << wvm_pkg::FRAC_BITS;
         step_ff  [vs_idx] <= vstart_step;
      end
      if (vmul && !vstop) begin
         if (vloop) begin
            pos_ff[cnt_ff]  <= lstart_ff[cnt_ff];
            vend_ff[cnt_ff] <= lend_ff[cnt_ff];
         end else begin
            pos_ff[cnt_ff] <= np[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wvm_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cur_ff  <= cur_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      scl_ff  <= scl_in;
      keep_ff <= keep_in;
      done_ff <= done_in;
      mix_ff  <= mix_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_mixed_sample = mix_ff;
   assign rsp_done_mask    = done_ff;

endmodule

// ===== design/wavetable_voice_mixer.sv =====
// wavetable_voice_mixer: top level, configuration registers and the front/back split
// depends on wvm_pkg, wvm_front and wvm_back
//
// multi-voice wavetable mixer over a 16-bit sample memory. a request is taken
// when start is high and busy is low; it can write a sample word, start a
// voice, set a voice gain or ask for one output tick. only a tick gives a
// result: rsp_valid is high for exactly one cycle and the receiver cannot
// stall it, so sample it then. a two-entry request queue sits in front of
// the back end, so up to two requests may be taken while one is at work.
// a tick is taken from the queue, then each voice in turn passes through the
// shared multiply-accumulate, which reads, scales and sums it, then the master
// gain and clamp are applied; the strobe follows in the next cycle. a voice
// start is taken from the queue, then runs the bit-serial phase step division
// and picks up the quotient (with a zero sample rate it is done as it is taken
// from the queue); writes and gain sets are done as they are taken from the
// queue. configuration writes land at once, with no handshake.
module wavetable_voice_mixer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_voice,
   input  logic [15:0]        req_address,
   input  logic signed [15:0] req_sample_data,
   input  logic [16:0]        req_track_length,
   input  logic [15:0]        req_loop_start,
   input  logic [16:0]        req_loop_end,
   input  logic [17:0]        req_frequency,
   input  logic [7:0]         req_voice_volume,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_mixed_sample,
   output logic [7:0]         rsp_done_mask,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [17:0]        csr_data
);

   wvm_pkg::cfg_type          cfg_ff, cfg_in;
   wvm_pkg::req_type          req;
   wvm_pkg::queue_status_type qstat;
   logic                      pop;

   // register writes; an index past the list is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            wvm_pkg::CSR_SAMPLE_RATE:   cfg_in.sample_rate   = csr_data;
            wvm_pkg::CSR_MASTER_VOLUME: cfg_in.master_volume = csr_data[7:0];
            wvm_pkg::CSR_MUTED:         cfg_in.muted         = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_rate   <= 18'd44100;
         cfg_ff.master_volume <= 8'd255;
         cfg_ff.muted         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pack the request fields
   always_comb begin
      req.kind         = wvm_pkg::kind_type'(req_kind);
      req.voice        = req_voice;
      req.address      = req_address;
      req.sample_data  = req_sample_data;
      req.track_length = req_track_length;
      req.loop_start   = req_loop_start;
      req.loop_end     = req_loop_end;
      req.frequency    = req_frequency;
      req.voice_volume = req_voice_volume;
   end

   // front: request queue
   wvm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req),
      .pop    (pop),
      .busy   (busy),
      .status (qstat)
   );

   // back: voices, memory and mixing
   wvm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .qstat            (qstat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_done_mask    (rsp_done_mask)
   );

   // a result strobe is never held high
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // the clamp never lets the most negative code out
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mixed_sample != 16'sh8000)
      else $error("clamp broken");

   // the queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qstat.count <= 2'(wvm_pkg::QDEPTH))
      else $error("request queue overflow");

   // a pop only happens when the queue holds a request
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.valid)
      else $error("pop from empty queue");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for the wavetable voice mixer
// depends on wvm_pkg and wavetable_voice_mixer; a directed table, then random phases
// every request is mirrored into an in-bench mixer model and each tick result is compared
module testbench;

   typedef struct {
      logic signed [15:0] mixed;
      logic [7:0]         mask;
   } mix_result_type;

   typedef struct {
      wvm_pkg::req_type   r;
      bit                 typed;
      logic signed [15:0] mixed;
      logic [7:0]         mask;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_kind = '0;
   logic [2:0]         req_voice = '0;
   logic [15:0]        req_address = '0;
   logic signed [15:0] req_sample_data = '0;
   logic [16:0]        req_track_length = '0;
   logic [15:0]        req_loop_start = '0;
   logic [16:0]        req_loop_end = '0;
   logic [17:0]        req_frequency = '0;
   logic [7:0]         req_voice_volume = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_mixed_sample;
   logic [7:0]         rsp_done_mask;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [17:0]        csr_data = '0;

   wavetable_voice_mixer u_top (.*);

   always #1 clock = ~clock;

   // mirror of the mixer state
   logic [15:0] sample_mem [wvm_pkg::SAMPLE_DEPTH];
   bit          written [wvm_pkg::SAMPLE_DEPTH];
   logic [31:0] vpos [wvm_pkg::NUM_VOICES];
   logic [31:0] vend [wvm_pkg::NUM_VOICES];
   logic [31:0] vloop_lo [wvm_pkg::NUM_VOICES];
   logic [31:0] vloop_hi [wvm_pkg::NUM_VOICES];
   logic [31:0] vstep [wvm_pkg::NUM_VOICES];
   logic [15:0] vbase [wvm_pkg::NUM_VOICES];
   logic [7:0]  vgain [wvm_pkg::NUM_VOICES];
   bit          vact [wvm_pkg::NUM_VOICES];
   logic [17:0] rate_reg = 18'd44100;
   logic [7:0]  master_reg = 8'd255;
   logic        mute_reg = 1'b0;

   mix_result_type expected_mix[$];
   int             errors = 0;
   stim_row_type   directed[$];

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // one tick of the mixer: walk the active voices, sum, master gain, clamp
   function automatic mix_result_type mix_tick();
      mix_result_type res;
      longint      acc;
      longint      s;
      longint      scaled;
      logic [63:0] np;
      logic [15:0] addr;
      acc = 0;
      res.mask = '0;
      for (int i = 0; i < wvm_pkg::NUM_VOICES; i++) begin
         if (!vact[i]) continue;
         addr = vbase[i] + 16'(vpos[i] >> wvm_pkg::FRAC_BITS);
         s = longint'($signed(sample_mem[addr])) * longint'(vgain[i]);
         np = 64'(vpos[i]) + 64'(vstep[i]);
         if (np >= 64'(vend[i])) begin
            if (vloop_hi[i] == 0) begin
               vact[i] = 0;
               res.mask[i] = 1'b1;
               continue;
            end
            np = 64'(vloop_lo[i]);
            vend[i] = vloop_hi[i];
         end
         vpos[i] = np[31:0];
         acc += s;
      end
      scaled = ((acc >>> 8) * longint'(mute_reg ? 8'd0 : master_reg)) >>> 8;
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32767) scaled = -32767;
      res.mixed = 16'(scaled);
      return res;
   endfunction

   // update the mirror for an accepted request
   function automatic void apply_request(wvm_pkg::req_type r);
      logic [63:0] q;
      case (r.kind)
         wvm_pkg::KIND_WRITE: begin
            sample_mem[r.address] = r.sample_data;
            written[r.address] = 1;
         end
         wvm_pkg::KIND_START: begin
            q = 0;
            if (rate_reg != 0)
               q = (64'(r.frequency) << wvm_pkg::FRAC_BITS) / 64'(rate_reg);
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            vbase[r.voice] = r.address;
            vpos[r.voice] = 0;
            vend[r.voice] = 32'(r.track_length) << wvm_pkg::FRAC_BITS;
            vloop_lo[r.voice] = 32'(r.loop_start) << wvm_pkg::FRAC_BITS;
            vloop_hi[r.voice] = 32'(r.loop_end) << wvm_pkg::FRAC_BITS;
            vstep[r.voice] = q[31:0];
            vact[r.voice] = 1;
         end
         wvm_pkg::KIND_VOLUME: vgain[r.voice] = r.voice_volume;
         default: expected_mix.push_back(mix_tick());
      endcase
   endfunction

   // drive one request from a falling edge and hold it until taken
   task automatic issue(wvm_pkg::req_type r);
      req_kind <= r.kind;
      req_voice <= r.voice;
      req_address <= r.address;
      req_sample_data <= r.sample_data;
      req_track_length <= r.track_length;
      req_loop_start <= r.loop_start;
      req_loop_end <= r.loop_end;
      req_frequency <= r.frequency;
      req_voice_volume <= r.voice_volume;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      apply_request(r);
      @(negedge clock);
   endtask

   // sender gap with the given chance, start dropped only inside the gap
   task automatic sender_gap(int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // make sure no active voice is about to read a word that was never stored
   task automatic fill_reads(int pct);
      wvm_pkg::req_type w;
      logic [15:0]      addr;
      for (int i = 0; i < wvm_pkg::NUM_VOICES; i++) begin
         if (!vact[i]) continue;
         addr = vbase[i] + 16'(vpos[i] >> wvm_pkg::FRAC_BITS);
         if (written[addr]) continue;
         w = '0;
         w.kind = wvm_pkg::KIND_WRITE;
         w.address = addr;
         w.sample_data = 16'($urandom);
         sender_gap(pct);
         issue(w);
      end
   endtask

   task automatic send(wvm_pkg::req_type r, int pct);
      if (r.kind == wvm_pkg::KIND_TICK) fill_reads(pct);
      sender_gap(pct);
      issue(r);
   endtask

   // drain: wait for every tick result, then let queued starts finish
   task automatic settle();
      start <= 1'b0;
      while (expected_mix.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [17:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         wvm_pkg::CSR_SAMPLE_RATE:   rate_reg = val;
         wvm_pkg::CSR_MASTER_VOLUME: master_reg = val[7:0];
         default:                    mute_reg = val[0];
      endcase
   endtask

   function automatic void add_row(wvm_pkg::kind_type k, int v, int addr, int data, int tl,
                                   int ls, int le, int freq, int vol, bit typed = 0,
                                   int mixed = 0, int mask = 0);
      stim_row_type row;
      row.r = '0;
      row.r.kind = k;
      row.r.voice = 3'(v);
      row.r.address = 16'(addr);
      row.r.sample_data = 16'(data);
      row.r.track_length = 17'(tl);
      row.r.loop_start = 16'(ls);
      row.r.loop_end = 17'(le);
      row.r.frequency = 18'(freq);
      row.r.voice_volume = 8'(vol);
      row.typed = typed;
      row.mixed = 16'(mixed);
      row.mask = 8'(mask);
      directed.push_back(row);
   endfunction

   function automatic wvm_pkg::req_type random_request();
      wvm_pkg::req_type r;
      int               pick;
      r = '0;
      r.voice = 3'($urandom);
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.kind = wvm_pkg::KIND_WRITE;
         r.address = 16'($urandom);
         r.sample_data = 16'($urandom);
      end else if (pick < 35) begin
         r.kind = wvm_pkg::KIND_START;
         r.address = 16'($urandom);
         // mostly short tracks and loops, now and then the full field range
         if ($urandom_range(9) == 0) begin
            r.track_length = 17'($urandom);
            r.loop_start = 16'($urandom);
            r.loop_end = 17'($urandom);
            r.frequency = 18'($urandom);
         end else begin
            r.track_length = 17'($urandom_range(0, 16));
            r.loop_start = 16'($urandom_range(0, 12));
            r.loop_end = ($urandom_range(2) == 0) ? 17'd0 : 17'($urandom_range(1, 20));
            r.frequency = 18'($urandom_range(0, 200000));
         end
      end else if (pick < 45) begin
         r.kind = wvm_pkg::KIND_VOLUME;
         r.voice_volume = 8'($urandom);
      end else begin
         r.kind = wvm_pkg::KIND_TICK;
      end
      return r;
   endfunction

   // result checker: the receiver cannot stall, so every strobe is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_mix.size() == 0) begin
            report_mismatch("result with no tick waiting", rsp_mixed_sample, 0);
         end else begin
            if (rsp_mixed_sample !== expected_mix[0].mixed)
               report_mismatch("mixed_sample", rsp_mixed_sample, expected_mix[0].mixed);
            if (rsp_done_mask !== expected_mix[0].mask)
               report_mismatch("done_mask", rsp_done_mask, expected_mix[0].mask);
            void'(expected_mix.pop_front());
         end
      end
   end

   initial begin
      int idle_pct [4];
      idle_pct = '{0, 60, 0, 24};
      for (int i = 0; i < wvm_pkg::NUM_VOICES; i++) begin
         vpos[i] = 0; vend[i] = 0; vloop_lo[i] = 0; vloop_hi[i] = 0;
         vstep[i] = 0; vbase[i] = 0; vgain[i] = 0; vact[i] = 0;
      end

      // tick after reset, one-shot voice, loop on a single word, clamp,
      // zero track length with loop start past loop end, address extremes
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(wvm_pkg::KIND_WRITE, 0, 16'h0100, 32767, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_WRITE, 0, 16'h0101, -32768, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_WRITE, 0, 16'hFFFF, 16'h5555, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_VOLUME, 0, 0, 0, 0, 0, 0, 0, 255);
      add_row(wvm_pkg::KIND_VOLUME, 7, 0, 0, 0, 0, 0, 0, 255);
      add_row(wvm_pkg::KIND_START, 0, 16'h0100, 0, 2, 0, 0, 44100, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32511, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 8'h01);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
      add_row(wvm_pkg::KIND_START, 7, 16'hFFFF, 0, 1, 0, 1, 44100, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 21674, 0);
      add_row(wvm_pkg::KIND_START, 0, 16'h0100, 0, 65536, 65535, 65536, 0, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32767, 0);
      add_row(wvm_pkg::KIND_VOLUME, 1, 0, 0, 0, 0, 0, 0, 255);
      add_row(wvm_pkg::KIND_START, 1, 16'h0101, 0, 0, 3, 2, 262143, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_VOLUME, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_VOLUME, 7, 0, 0, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_WRITE, 0, 16'h0000, 0, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_START, 2, 16'h0000, 0, 131071, 65535, 131071, 262143, 0);
      add_row(wvm_pkg::KIND_VOLUME, 2, 0, 0, 0, 0, 0, 0, 128);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(wvm_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[n]) begin
         send(directed[n].r, 0);
         if (directed[n].typed) begin
            if (expected_mix[$].mixed !== directed[n].mixed)
               report_mismatch("table mixed_sample", expected_mix[$].mixed, directed[n].mixed);
            if (expected_mix[$].mask !== directed[n].mask)
               report_mismatch("table done_mask", expected_mix[$].mask, directed[n].mask);
         end
      end

      // random phases, each under its own register setting
      for (int p = 0; p < 4; p++) begin
         settle();
         case (p)
            0: begin
               write_reg(wvm_pkg::CSR_SAMPLE_RATE, 18'd8000);
               write_reg(wvm_pkg::CSR_MASTER_VOLUME, 18'd255);
            end
            1: begin
               write_reg(wvm_pkg::CSR_SAMPLE_RATE, 18'd192000);
               write_reg(wvm_pkg::CSR_MASTER_VOLUME, 18'd0);
            end
            2: begin
               write_reg(wvm_pkg::CSR_SAMPLE_RATE, 18'h3FFFF);
               write_reg(wvm_pkg::CSR_MASTER_VOLUME, 18'($urandom_range(1, 254)));
               write_reg(wvm_pkg::CSR_MUTED, 18'd1);
            end
            default: begin
               write_reg(wvm_pkg::CSR_SAMPLE_RATE,
                         ($urandom_range(3) == 0) ? 18'd0 : 18'd44100);
               write_reg(wvm_pkg::CSR_MASTER_VOLUME, 18'($urandom_range(0, 255)));
               write_reg(wvm_pkg::CSR_MUTED, 18'd0);
            end
         endcase
         for (int n = 0; n < 125; n++)
            send(random_request(), idle_pct[p]);
      end

      start <= 1'b0;
      while (expected_mix.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/wvm_pkg.sv
design/wvm_divider.sv
design/wvm_front.sv
design/wvm_back.sv
design/wavetable_voice_mixer.sv
dv/testbench.sv
